// File: rtl/tmcbs_pkg.sv
// Package for the texture mip chain byte size block.
// Holds the format table, block reciprocals, command and status types.
// No dependencies.
package tmcbs_pkg;

  localparam int unsigned MaxMipLevelsDef = 15;
  localparam int unsigned FmtW            = 5;
  localparam int unsigned DimW            = 15;
  localparam int unsigned LevelsW         = 4;
  localparam int unsigned LayersW         = 12;
  localparam int unsigned TotalW          = 32;
  localparam int unsigned BlkW            = 4;
  localparam int unsigned ShiftW          = 3;
  localparam int unsigned RecipW          = 21;
  localparam int unsigned RecipShift      = 20;
  localparam int unsigned InDataW         = 56;
  localparam int unsigned OutDataW        = 48;

  localparam logic [FmtW-1:0] FmtRgba8   = 5'd0;
  localparam logic [FmtW-1:0] FmtBgra8   = 5'd1;
  localparam logic [FmtW-1:0] FmtR8      = 5'd2;
  localparam logic [FmtW-1:0] FmtR16     = 5'd3;
  localparam logic [FmtW-1:0] FmtD16     = 5'd4;
  localparam logic [FmtW-1:0] FmtD32     = 5'd5;
  localparam logic [FmtW-1:0] FmtBc1     = 5'd6;
  localparam logic [FmtW-1:0] FmtBc2     = 5'd7;
  localparam logic [FmtW-1:0] FmtBc3     = 5'd8;
  localparam logic [FmtW-1:0] FmtBc4     = 5'd9;
  localparam logic [FmtW-1:0] FmtBc5     = 5'd10;
  localparam logic [FmtW-1:0] FmtBc6h    = 5'd11;
  localparam logic [FmtW-1:0] FmtBc7     = 5'd12;
  localparam logic [FmtW-1:0] FmtEtcRgb  = 5'd13;
  localparam logic [FmtW-1:0] FmtEtcA1   = 5'd14;
  localparam logic [FmtW-1:0] FmtEtcRgba = 5'd15;
  localparam logic [FmtW-1:0] FmtAstc4x4   = 5'd16;
  localparam logic [FmtW-1:0] FmtAstc5x4   = 5'd17;
  localparam logic [FmtW-1:0] FmtAstc5x5   = 5'd18;
  localparam logic [FmtW-1:0] FmtAstc6x5   = 5'd19;
  localparam logic [FmtW-1:0] FmtAstc6x6   = 5'd20;
  localparam logic [FmtW-1:0] FmtAstc8x5   = 5'd21;
  localparam logic [FmtW-1:0] FmtAstc8x6   = 5'd22;
  localparam logic [FmtW-1:0] FmtAstc8x8   = 5'd23;
  localparam logic [FmtW-1:0] FmtAstc10x5  = 5'd24;
  localparam logic [FmtW-1:0] FmtAstc10x6  = 5'd25;
  localparam logic [FmtW-1:0] FmtAstc10x8  = 5'd26;
  localparam logic [FmtW-1:0] FmtAstc10x10 = 5'd27;
  localparam logic [FmtW-1:0] FmtAstc12x10 = 5'd28;
  localparam logic [FmtW-1:0] FmtAstc12x12 = 5'd29;

  typedef struct packed {
    logic [BlkW-1:0]   blk_w;
    logic [BlkW-1:0]   blk_h;
    logic [ShiftW-1:0] unit_shift;
    logic              compressed;
    logic              bad;
  } fmt_info_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic mult;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_nz;
    logic pipe_empty;
  } sts_t;

  typedef enum logic [2:0] {
    StIdle,
    StIter,
    StDrain,
    StMult,
    StOut
  } state_e;

  function automatic fmt_info_t mk_info(input logic [BlkW-1:0] bw, input logic [BlkW-1:0] bh,
                                        input logic [ShiftW-1:0] sh, input logic comp);
    fmt_info_t r;
    r.blk_w      = bw;
    r.blk_h      = bh;
    r.unit_shift = sh;
    r.compressed = comp;
    r.bad        = 1'b0;
    return r;
  endfunction

  function automatic fmt_info_t fmt_lookup(input logic [FmtW-1:0] fmt);
    fmt_info_t r;
    r.blk_w      = 4'd1;
    r.blk_h      = 4'd1;
    r.unit_shift = 3'd0;
    r.compressed = 1'b0;
    r.bad        = 1'b1;
    unique case (fmt)
      FmtRgba8:     r = mk_info(4'd1, 4'd1, 3'd2, 1'b0);
      FmtBgra8:     r = mk_info(4'd1, 4'd1, 3'd2, 1'b0);
      FmtR8:        r = mk_info(4'd1, 4'd1, 3'd0, 1'b0);
      FmtR16:       r = mk_info(4'd1, 4'd1, 3'd1, 1'b0);
      FmtD16:       r = mk_info(4'd1, 4'd1, 3'd1, 1'b0);
      FmtD32:       r = mk_info(4'd1, 4'd1, 3'd2, 1'b0);
      FmtBc1:       r = mk_info(4'd4, 4'd4, 3'd3, 1'b1);
      FmtBc2:       r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtBc3:       r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtBc4:       r = mk_info(4'd4, 4'd4, 3'd3, 1'b1);
      FmtBc5:       r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtBc6h:      r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtBc7:       r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtEtcRgb:    r = mk_info(4'd4, 4'd4, 3'd3, 1'b1);
      FmtEtcA1:     r = mk_info(4'd4, 4'd4, 3'd3, 1'b1);
      FmtEtcRgba:   r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtAstc4x4:   r = mk_info(4'd4, 4'd4, 3'd4, 1'b1);
      FmtAstc5x4:   r = mk_info(4'd5, 4'd4, 3'd4, 1'b1);
      FmtAstc5x5:   r = mk_info(4'd5, 4'd5, 3'd4, 1'b1);
      FmtAstc6x5:   r = mk_info(4'd6, 4'd5, 3'd4, 1'b1);
      FmtAstc6x6:   r = mk_info(4'd6, 4'd6, 3'd4, 1'b1);
      FmtAstc8x5:   r = mk_info(4'd8, 4'd5, 3'd4, 1'b1);
      FmtAstc8x6:   r = mk_info(4'd8, 4'd6, 3'd4, 1'b1);
      FmtAstc8x8:   r = mk_info(4'd8, 4'd8, 3'd4, 1'b1);
      FmtAstc10x5:  r = mk_info(4'd10, 4'd5, 3'd4, 1'b1);
      FmtAstc10x6:  r = mk_info(4'd10, 4'd6, 3'd4, 1'b1);
      FmtAstc10x8:  r = mk_info(4'd10, 4'd8, 3'd4, 1'b1);
      FmtAstc10x10: r = mk_info(4'd10, 4'd10, 3'd4, 1'b1);
      FmtAstc12x10: r = mk_info(4'd12, 4'd10, 3'd4, 1'b1);
      FmtAstc12x12: r = mk_info(4'd12, 4'd12, 3'd4, 1'b1);
      default: ;
    endcase
    return r;
  endfunction

  // ceil(2^20 / d); exact floor division for dividends below 2^16
  function automatic logic [RecipW-1:0] recip(input logic [BlkW-1:0] d);
    logic [RecipW-1:0] r;
    r = 21'd1048576;
    unique case (d)
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd8:    r = 21'd131072;
      4'd10:   r = 21'd104858;
      4'd12:   r = 21'd87382;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tmcbs_ctrl.sv
// Controller of the mip chain byte size block: sequences load, level
// iteration, drain, layer multiply and output. Depends on tmcbs_pkg.
module tmcbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  tmcbs_pkg::sts_t sts_i,
  output tmcbs_pkg::cmd_t cmd_o
);
  import tmcbs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StIter;
      StIter:  if (!sts_i.cnt_nz) state_d = StDrain;
      StDrain: if (sts_i.pipe_empty) state_d = StMult;
      StMult:  state_d = StOut;
      StOut:   if (!out_valid_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      StIter:  cmd_o.issue = sts_i.cnt_nz;
      StDrain: ;
      StMult:  cmd_o.mult = 1'b1;
      StOut:   cmd_o.out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/tmcbs_datapath.sv
// Datapath of the mip chain byte size block: per-level block count pipeline,
// accumulator, layer multiply and output register. Depends on tmcbs_pkg.
module tmcbs_datapath #(
  parameter int unsigned MAX_MIP_LEVELS = tmcbs_pkg::MaxMipLevelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tmcbs_pkg::cmd_t                  cmd_i,
  output tmcbs_pkg::sts_t                  sts_o,
  input  logic [tmcbs_pkg::FmtW-1:0]       format_code_i,
  input  logic [tmcbs_pkg::DimW-1:0]       base_width_i,
  input  logic [tmcbs_pkg::DimW-1:0]       base_height_i,
  input  logic [tmcbs_pkg::LevelsW-1:0]    mip_levels_i,
  input  logic [tmcbs_pkg::LayersW-1:0]    layer_count_i,
  output logic [tmcbs_pkg::TotalW-1:0]     total_bytes_o,
  output logic                             size_overflow_o,
  output logic [tmcbs_pkg::BlkW-1:0]       block_width_o,
  output logic [tmcbs_pkg::BlkW-1:0]       block_height_o,
  output logic                             compressed_o,
  output logic                             bad_format_o
);
  import tmcbs_pkg::*;

  localparam int unsigned LvlW   = $clog2(MAX_MIP_LEVELS + 1);
  localparam int unsigned SumW   = TotalW + $clog2(MAX_MIP_LEVELS);
  localparam int unsigned ProdW  = SumW + LayersW;
  localparam int unsigned NumW   = DimW + 1;
  localparam int unsigned QProdW = NumW + RecipW;
  localparam int unsigned AreaW  = 2 * NumW;
  localparam int unsigned TermW  = AreaW + 4;

  fmt_info_t          info_q, info_d;
  logic [DimW-1:0]    w_q, w_d, h_q, h_d;
  logic [LvlW-1:0]    cnt_q, cnt_d;
  logic [LayersW-1:0] layers_q;
  logic [RecipW-1:0]  rw_q, rh_q;
  logic               v1_q, v2_q;
  logic [NumW-1:0]    qw_q, qh_q;
  logic [AreaW-1:0]   area_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [ProdW-1:0]   prod_q;
  logic [LvlW-1:0]    lvl_sat;
  logic [DimW-1:0]    wc, hc;
  logic [NumW-1:0]    nw, nh;
  logic [QProdW-1:0]  pw, ph;
  logic [TermW-1:0]   term;

  assign info_d = fmt_lookup(format_code_i);

  always_comb begin
    if (5'(mip_levels_i) > 5'(MAX_MIP_LEVELS)) begin
      lvl_sat = LvlW'(MAX_MIP_LEVELS);
    end else begin
      lvl_sat = LvlW'(mip_levels_i);
    end
  end

  always_comb begin
    w_d   = w_q;
    h_d   = h_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      w_d   = base_width_i;
      h_d   = base_height_i;
      cnt_d = lvl_sat;
    end else if (cmd_i.issue) begin
      w_d   = w_q >> 1;
      h_d   = h_q >> 1;
      cnt_d = cnt_q - LvlW'(1);
    end
  end

  assign wc = (w_q == '0) ? DimW'(1) : w_q;
  assign hc = (h_q == '0) ? DimW'(1) : h_q;
  assign nw = NumW'(wc) + NumW'(info_q.blk_w) - NumW'(1);
  assign nh = NumW'(hc) + NumW'(info_q.blk_h) - NumW'(1);
  assign pw = QProdW'(nw) * QProdW'(rw_q);
  assign ph = QProdW'(nh) * QProdW'(rh_q);
  assign term = TermW'(area_q) << info_q.unit_shift;

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.load) begin
      sum_d = '0;
    end else if (v2_q) begin
      sum_d = sum_q + SumW'(term);
    end
  end

  assign sts_o.cnt_nz     = (cnt_q != '0);
  assign sts_o.pipe_empty = !v1_q && !v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      v1_q  <= cmd_i.issue;
      v2_q  <= v1_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    sum_q  <= sum_d;
    qw_q   <= pw[RecipShift +: NumW];
    qh_q   <= ph[RecipShift +: NumW];
    area_q <= AreaW'(qw_q) * AreaW'(qh_q);
    if (cmd_i.load) begin
      info_q   <= info_d;
      layers_q <= layer_count_i;
      rw_q     <= recip(info_d.blk_w);
      rh_q     <= recip(info_d.blk_h);
    end
    if (cmd_i.mult) begin
      prod_q <= ProdW'(sum_q) * ProdW'(layers_q);
    end
    if (cmd_i.out_load) begin
      total_bytes_o   <= info_q.bad ? '0 : prod_q[TotalW-1:0];
      size_overflow_o <= !info_q.bad && (prod_q[ProdW-1:TotalW] != '0);
      block_width_o   <= info_q.blk_w;
      block_height_o  <= info_q.blk_h;
      compressed_o    <= info_q.compressed;
      bad_format_o    <= info_q.bad;
    end
  end

endmodule

// File: rtl/texture_mip_chain_byte_size.sv
// Top level of the texture mip chain byte size block.
// Joins tmcbs_ctrl and tmcbs_datapath; depends on tmcbs_pkg.
//
// One descriptor is taken at a time. A descriptor's L mip levels (after
// saturation to MAX_MIP_LEVELS) are issued one per cycle through the shared
// block count pipeline (reciprocal divide, block area, accumulate) until the
// level count runs out; the pipeline then drains, the layer multiply runs
// and the output register is loaded once any earlier result has been taken.
// The controller returns to idle, where the next descriptor is accepted.
// The next descriptor is accepted while a finished result waits to be
// taken. Zero width or height counts as one pixel; codes above the last ASTC
// format give a zero total with bad_format set.
module texture_mip_chain_byte_size #(
  parameter int unsigned MAX_MIP_LEVELS = tmcbs_pkg::MaxMipLevelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // format_code[4:0], base_width[19:5], base_height[34:20],
  // mip_levels[38:35], layer_count[50:39], zero pad [55:51]
  input  logic [tmcbs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // total_bytes[31:0], size_overflow[32], block_width[36:33],
  // block_height[40:37], compressed[41], bad_format[42], zero pad [47:43]
  output logic [tmcbs_pkg::OutDataW-1:0]   m_axis_tdata
);
  import tmcbs_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [TotalW-1:0]  total_bytes;
  logic               size_overflow;
  logic [BlkW-1:0]    block_width;
  logic [BlkW-1:0]    block_height;
  logic               compressed;
  logic               bad_format;

  tmcbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tmcbs_datapath #(
    .MAX_MIP_LEVELS (MAX_MIP_LEVELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .format_code_i   (s_axis_tdata[4:0]),
    .base_width_i    (s_axis_tdata[19:5]),
    .base_height_i   (s_axis_tdata[34:20]),
    .mip_levels_i    (s_axis_tdata[38:35]),
    .layer_count_i   (s_axis_tdata[50:39]),
    .total_bytes_o   (total_bytes),
    .size_overflow_o (size_overflow),
    .block_width_o   (block_width),
    .block_height_o  (block_height),
    .compressed_o    (compressed),
    .bad_format_o    (bad_format)
  );

  assign m_axis_tdata = {5'b0, bad_format, compressed, block_height, block_width,
                         size_overflow, total_bytes};

endmodule
